[hw/rtl/gpd3_pkg.sv]
// shared types and constants for the 3x3 grid peak detector
// used by the top level and its port checker
package gpd3_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int ROW_BITS       = 6;
    localparam int COLUMN_BITS    = 6;
    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MAX_HEIGHT     = 64;
    localparam int RESULT_SLOTS   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic [CFG_BITS-1:0] GRID_WIDTH_RESET  = 7'd20;
    localparam logic [CFG_BITS-1:0] GRID_HEIGHT_RESET = 7'd20;

    localparam logic KIND_PEAK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef pixel_t window_t [9];

    typedef struct packed {
        logic                   kind;
        pixel_t                 peak_value;
        logic [ROW_BITS-1:0]    peak_row;
        logic [COLUMN_BITS-1:0] peak_column;
        logic                   any_peak;
        pixel_t                 largest_peak;
        pixel_t                 smallest_peak;
    } result_t;

endpackage

[hw/rtl/gpd3_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module gpd3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                  wr_data,
    input  logic                              rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/grid_peak_detector_3x3.sv]
// top level of the 3x3 grid peak detector: line memory, window, peak logic, result queue
// depends on gpd3_pkg and gpd3_ram
//
// Pixels enter in raster order at one beat per cycle unless the decision stage stalls.
// The two previous rows live in one line memory of MAX_WIDTH entries, read when a pixel
// is taken and written back as the pixel leaves the decision stage. A pixel whose
// decisions yield results (up to four peak reports plus the frame summary on the final
// pixel) parks them in a five-entry pending set that drains one beat per cycle into the
// output register while the result side is ready; the input keeps taking one pixel per
// cycle as long as each item's results drain before the next item leaves the decision
// stage. The results of a pixel pass from the decision stage through the pending set
// into the output register. A write to either size register restarts the frame.
module grid_peak_detector_3x3
    import gpd3_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,

    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  logic [PIXEL_BITS-1:0]     pixel,

    output logic                      res_valid,
    input  logic                      res_ready,
    output logic                      kind,
    output logic [PIXEL_BITS-1:0]     peak_value,
    output logic [ROW_BITS-1:0]       peak_row,
    output logic [COLUMN_BITS-1:0]    peak_column,
    output logic                      any_peak,
    output logic [PIXEL_BITS-1:0]     largest_peak,
    output logic [PIXEL_BITS-1:0]     smallest_peak,
    output logic                      last
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int LINE_BITS = 2 * PIXEL_BITS;
    localparam int SEL_BITS  = $clog2(RESULT_SLOTS);

    function automatic logic [COL_BITS-1:0] last_col_of(input logic [CFG_BITS-1:0] gw);
        logic [COL_BITS-1:0] lc;
        if (gw == '0)
        begin
            lc = '0;
        end
        else if (32'(gw) > MAX_WIDTH)
        begin
            lc = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            lc = COL_BITS'(gw - 1'b1);
        end
        return lc;
    endfunction

    function automatic logic [ROW_BITS-1:0] last_row_of(input logic [CFG_BITS-1:0] gh);
        logic [ROW_BITS-1:0] lr;
        if (gh == '0)
        begin
            lr = '0;
        end
        else if (32'(gh) > MAX_HEIGHT)
        begin
            lr = ROW_BITS'(MAX_HEIGHT - 1);
        end
        else
        begin
            lr = ROW_BITS'(gh - 1'b1);
        end
        return lr;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] col_out(input logic [COL_BITS-1:0] c);
        logic [COL_BITS+COLUMN_BITS-1:0] ext;
        ext = {{COLUMN_BITS{1'b0}}, c};
        return ext[COLUMN_BITS-1:0];
    endfunction

    // center at window (wr, wc); neighbors off the grid edge or off the window are skipped
    function automatic logic is_peak(input window_t win, input int wr, input int wc,
                                     input logic up_ok, input logic dn_ok,
                                     input logic lf_ok, input logic rt_ok);
        logic   pk;
        logic   ok;
        pixel_t ctr;
        int     xr;
        int     xc;
        pk  = 1'b1;
        ctr = win[wr * 3 + wc];
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                xr = wr + dr;
                xc = wc + dc;
                ok = !(dr == 0 && dc == 0);
                if (dr < 0 && !up_ok) ok = 1'b0;
                if (dr > 0 && !dn_ok) ok = 1'b0;
                if (dc < 0 && !lf_ok) ok = 1'b0;
                if (dc > 0 && !rt_ok) ok = 1'b0;
                if (xr < 0 || xr > 2 || xc < 0 || xc > 2) ok = 1'b0;
                if (ok && ctr <= win[(xr * 3 + xc) % 9]) pk = 1'b0;
            end
        end
        return pk;
    endfunction

    // configuration, held as the last valid column and row
    logic [COL_BITS-1:0] last_col_reg;
    logic [ROW_BITS-1:0] last_row_reg;

    // position of the next pixel to be taken
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;

    // decision stage
    logic                 s1_valid_reg;
    pixel_t               s1_pixel_reg;
    logic [COL_BITS-1:0]  s1_col_reg;
    logic [ROW_BITS-1:0]  s1_row_reg;
    logic                 s1_fwd_reg;
    logic [LINE_BITS-1:0] fwd_reg;
    window_t              win_reg;
    window_t              win_next;

    pixel_t max_reg;
    pixel_t min_reg;
    logic   found_reg;

    logic [RESULT_SLOTS-1:0] pend_mask_reg;
    result_t                 pend_reg [RESULT_SLOTS];

    logic    res_valid_reg;
    result_t res_reg;
    logic    res_last_reg;

    logic                 pix_accept;
    logic                 cfg_accept;
    logic                 cfg_known;
    logic [LINE_BITS-1:0] ram_rd_data;
    logic [LINE_BITS-1:0] line_rd;
    pixel_t               top_pix;
    pixel_t               mid_pix;
    logic                 s1_adv;
    logic                 s1_last_row;
    logic                 s1_last_col;
    logic                 row_ge1;
    logic                 col_ge1;
    logic                 pk11;
    logic                 pk21;
    logic                 pk12;
    logic                 pk22;
    logic [RESULT_SLOTS-1:0] slot_mask;
    result_t              slot_res [RESULT_SLOTS];
    pixel_t               cand_val [RESULT_SLOTS-1];
    pixel_t               max_upd;
    pixel_t               min_upd;
    logic                 found_upd;
    logic                 drain;
    logic [RESULT_SLOTS-1:0] sel_onehot;
    logic [SEL_BITS-1:0]  sel_idx;
    logic [RESULT_SLOTS-1:0] pend_left;
    logic                 pend_done;
    logic [ROW_BITS-1:0]  row_m1;
    logic [COL_BITS-1:0]  col_m1;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_known  = (cfg_index == CFG_GRID_WIDTH) || (cfg_index == CFG_GRID_HEIGHT);

    gpd3_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_pix, s1_pixel_reg}),
        .rd_en   (pix_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // a one-pixel-wide grid reads the entry written back in the same cycle
    assign line_rd = s1_fwd_reg ? fwd_reg : ram_rd_data;
    assign top_pix = line_rd[LINE_BITS-1:PIXEL_BITS];
    assign mid_pix = line_rd[PIXEL_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i * 3]     = win_reg[i * 3 + 1];
            win_next[i * 3 + 1] = win_reg[i * 3 + 2];
        end
        win_next[2] = top_pix;
        win_next[5] = mid_pix;
        win_next[8] = s1_pixel_reg;
    end

    assign s1_last_row = (s1_row_reg == last_row_reg);
    assign s1_last_col = (s1_col_reg == last_col_reg);
    assign row_ge1     = (s1_row_reg != '0);
    assign col_ge1     = (s1_col_reg != '0);
    assign row_m1      = s1_row_reg - 1'b1;
    assign col_m1      = s1_col_reg - 1'b1;

    always_comb
    begin
        pk11 = is_peak(win_next, 1, 1, s1_row_reg > ROW_BITS'(1), row_m1 < last_row_reg,
                       s1_col_reg > COL_BITS'(1), col_m1 < last_col_reg);
        pk21 = is_peak(win_next, 2, 1, row_ge1, s1_row_reg < last_row_reg,
                       s1_col_reg > COL_BITS'(1), col_m1 < last_col_reg);
        pk12 = is_peak(win_next, 1, 2, s1_row_reg > ROW_BITS'(1), row_m1 < last_row_reg,
                       col_ge1, s1_col_reg < last_col_reg);
        pk22 = is_peak(win_next, 2, 2, row_ge1, s1_row_reg < last_row_reg,
                       col_ge1, s1_col_reg < last_col_reg);
    end

    // slots in report order: upper-left, lower-left, upper-right, lower-right, summary
    always_comb
    begin
        slot_mask[0] = row_ge1 && col_ge1 && pk11;
        slot_mask[1] = s1_last_row && col_ge1 && pk21;
        slot_mask[2] = s1_last_col && row_ge1 && pk12;
        slot_mask[3] = s1_last_col && s1_last_row && pk22;
        slot_mask[4] = s1_last_col && s1_last_row;

        cand_val[0] = win_next[4];
        cand_val[1] = win_next[7];
        cand_val[2] = win_next[5];
        cand_val[3] = win_next[8];

        max_upd   = max_reg;
        min_upd   = min_reg;
        found_upd = found_reg;
        for (int i = 0; i < RESULT_SLOTS - 1; i++)
        begin
            if (slot_mask[i])
            begin
                if (cand_val[i] > max_upd) max_upd = cand_val[i];
                if (cand_val[i] < min_upd) min_upd = cand_val[i];
                found_upd = 1'b1;
            end
        end

        for (int i = 0; i < RESULT_SLOTS; i++)
        begin
            slot_res[i] = '0;
        end
        slot_res[0].kind        = KIND_PEAK;
        slot_res[0].peak_value  = cand_val[0];
        slot_res[0].peak_row    = row_m1;
        slot_res[0].peak_column = col_out(col_m1);
        slot_res[1].kind        = KIND_PEAK;
        slot_res[1].peak_value  = cand_val[1];
        slot_res[1].peak_row    = s1_row_reg;
        slot_res[1].peak_column = col_out(col_m1);
        slot_res[2].kind        = KIND_PEAK;
        slot_res[2].peak_value  = cand_val[2];
        slot_res[2].peak_row    = row_m1;
        slot_res[2].peak_column = col_out(s1_col_reg);
        slot_res[3].kind        = KIND_PEAK;
        slot_res[3].peak_value  = cand_val[3];
        slot_res[3].peak_row    = s1_row_reg;
        slot_res[3].peak_column = col_out(s1_col_reg);
        slot_res[4].kind          = KIND_SUMMARY;
        slot_res[4].any_peak      = found_upd;
        slot_res[4].largest_peak  = found_upd ? max_upd : '0;
        slot_res[4].smallest_peak = found_upd ? min_upd : '0;
    end

    // pick the pending result with the lowest slot index, the first in report order
    always_comb
    begin
        sel_onehot = '0;
        sel_idx    = '0;
        for (int i = RESULT_SLOTS - 1; i >= 0; i--)
        begin
            if (pend_mask_reg[i])
            begin
                sel_onehot = '0;
                sel_onehot[i] = 1'b1;
                sel_idx = SEL_BITS'(i);
            end
        end
    end

    assign drain     = (pend_mask_reg != '0) && (!res_valid_reg || res_ready);
    assign pend_left = pend_mask_reg & ~sel_onehot;
    assign pend_done = (pend_mask_reg == '0) || (drain && (pend_left == '0));
    assign s1_adv    = s1_valid_reg && pend_done;
    assign pix_ready = !s1_valid_reg || s1_adv;
    assign pix_accept = pix_valid && pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= last_col_of(GRID_WIDTH_RESET);
            last_row_reg  <= last_row_of(GRID_HEIGHT_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            max_reg       <= '0;
            min_reg       <= '1;
            found_reg     <= 1'b0;
            pend_mask_reg <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_accept && cfg_known)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  last_col_reg <= last_col_of(cfg_data);
                    CFG_GRID_HEIGHT: last_row_reg <= last_row_of(cfg_data);
                    default: ;
                endcase
                col_reg   <= '0;
                row_reg   <= '0;
                max_reg   <= '0;
                min_reg   <= '1;
                found_reg <= 1'b0;
            end
            else
            begin
                if (pix_accept)
                begin
                    if (col_reg == last_col_reg)
                    begin
                        col_reg <= '0;
                        row_reg <= (row_reg == last_row_reg) ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                if (s1_adv)
                begin
                    if (slot_mask[4])
                    begin
                        max_reg   <= '0;
                        min_reg   <= '1;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        max_reg   <= max_upd;
                        min_reg   <= min_upd;
                        found_reg <= found_upd;
                    end
                end
            end

            if (pix_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= s1_valid_reg && (s1_col_reg == col_reg);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                win_reg       <= win_next;
                pend_mask_reg <= slot_mask;
            end
            else if (drain)
            begin
                pend_mask_reg <= pend_left;
            end

            if (drain)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            fwd_reg      <= {mid_pix, s1_pixel_reg};
        end
        if (s1_adv)
        begin
            pend_reg <= slot_res;
        end
        if (drain)
        begin
            res_reg      <= pend_reg[sel_idx];
            res_last_reg <= (pend_left == '0);
        end
    end

    assign res_valid     = res_valid_reg;
    assign kind          = res_reg.kind;
    assign peak_value    = res_reg.peak_value;
    assign peak_row      = res_reg.peak_row;
    assign peak_column   = res_reg.peak_column;
    assign any_peak      = res_reg.any_peak;
    assign largest_peak  = res_reg.largest_peak;
    assign smallest_peak = res_reg.smallest_peak;
    assign last          = res_last_reg;

endmodule

[hw/rtl/gpd3_checker.sv]
// port-level checks on the result channel of the 3x3 grid peak detector
// depends on gpd3_pkg; bound to grid_peak_detector_3x3 below
module gpd3_checker
    import gpd3_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic                   kind,
    input logic [PIXEL_BITS-1:0]  peak_value,
    input logic [ROW_BITS-1:0]    peak_row,
    input logic [COLUMN_BITS-1:0] peak_column,
    input logic                   any_peak,
    input logic [PIXEL_BITS-1:0]  largest_peak,
    input logic [PIXEL_BITS-1:0]  smallest_peak,
    input logic                   last
);

    // a stalled beat stays
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(kind) && $stable(peak_value)
            && $stable(peak_row) && $stable(peak_column) && $stable(any_peak)
            && $stable(largest_peak) && $stable(smallest_peak) && $stable(last))
        else $error("result payload changed while stalled");

    // the summary closes the burst of the frame's final pixel
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_SUMMARY |-> last)
        else $error("summary beat without last");

    a_peak_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_PEAK |-> !any_peak && largest_peak == '0
            && smallest_peak == '0)
        else $error("peak beat carries summary fields");

    a_summary_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_SUMMARY |-> peak_value == '0 && peak_row == '0
            && peak_column == '0
            && (any_peak ? (largest_peak >= smallest_peak)
                         : (largest_peak == '0 && smallest_peak == '0)))
        else $error("summary fields inconsistent");

endmodule

bind grid_peak_detector_3x3 gpd3_checker u_gpd3_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .kind          (kind),
    .peak_value    (peak_value),
    .peak_row      (peak_row),
    .peak_column   (peak_column),
    .any_peak      (any_peak),
    .largest_peak  (largest_peak),
    .smallest_peak (smallest_peak),
    .last          (last)
);
